// ===== rtl/mgc_pkg.sv =====
// shared constants and the coefficient table for the magma colormap
// no dependencies
`timescale 1ns / 1ps

package mgc_pkg;

  localparam int POS_W      = 17;
  localparam int BYTE_W     = 8;
  localparam int DEG        = 6;
  localparam int NCH        = 3;
  localparam int TABLE_FRAC = 24;
  localparam int INT_BITS   = 9;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  // signed q8.24, index [channel][power]
  localparam longint MAGMA_Q24 [NCH][DEG+1] = '{
    '{-64'sd35844, 64'sd4222163, 64'sd140152119, -64'sd464204311,
      64'sd875370368, -64'sd851754516, 64'sd312990794},
    '{-64'sd12577, 64'sd11366954, -64'sd60024173, 64'sd239322469,
      -64'sd468815915, 64'sd487320794, -64'sd192766412},
    '{-64'sd90364, 64'sd41842823, 64'sd5275896, -64'sd228995798,
      64'sd217167127, 64'sd71037299, -64'sd93985318}
  };

  // table entry brought to frac fraction bits, ties away from zero
  function automatic longint coef_fix(int ch, int k, int frac);
    longint v;
    longint mag;
    int     sh;
    v   = MAGMA_Q24[ch][k];
    mag = (v < 0) ? -v : v;
    if (frac >= TABLE_FRAC) begin
      mag = mag <<< (frac - TABLE_FRAC);
    end else begin
      sh  = TABLE_FRAC - frac;
      mag = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
    end
    return (v < 0) ? -mag : mag;
  endfunction

endpackage

// ===== rtl/mgc_fold.sv =====
// input stage: saturates the position and folds it into the mirrored ramp
// depends on mgc_pkg
`timescale 1ns / 1ps

module mgc_fold import mgc_pkg::*; #(
  parameter int POS_FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [POS_W-1:0]         position_i,
  output logic                     valid_o,
  output logic [POS_FRAC_BITS:0]   u_o
);

  localparam int UW = POS_FRAC_BITS + 1;
  localparam int CW = (POS_W > UW) ? POS_W : UW;

  logic [CW-1:0]   pos_ext;
  logic [CW-1:0]   one_ext;
  logic [UW-1:0]   t_sat;
  logic [UW:0]     dbl;
  logic [UW:0]     one_w;
  logic [UW:0]     fold;
  logic [UW-1:0]   u_d, u_q;
  logic            valid_q;

  always_comb begin
    pos_ext = CW'(position_i);
    one_ext = CW'(1) << POS_FRAC_BITS;
    t_sat   = (pos_ext > one_ext) ? one_ext[UW-1:0] : pos_ext[UW-1:0];
    dbl     = {t_sat, 1'b0};
    one_w   = (UW+1)'(1) << POS_FRAC_BITS;
    fold    = (dbl >= one_w) ? ((one_w << 1) - dbl) : dbl;
    u_d     = fold[UW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q <= u_d;
  end

  assign valid_o = valid_q;
  assign u_o     = u_q;

endmodule

// ===== rtl/mgc_horner_stage.sv =====
// one horner step for all channels: multiply stage, then shift and add stage
// depends on mgc_pkg
`timescale 1ns / 1ps

module mgc_horner_stage import mgc_pkg::*; #(
  parameter int POS_FRAC_BITS  = 16,
  parameter int COEF_FRAC_BITS = 24,
  parameter int POWER          = 0
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       valid_i,
  input  logic        [POS_FRAC_BITS:0]              u_i,
  input  logic signed [COEF_FRAC_BITS+INT_BITS-1:0]  acc_i [NCH],
  output logic                                       valid_o,
  output logic        [POS_FRAC_BITS:0]              u_o,
  output logic signed [COEF_FRAC_BITS+INT_BITS-1:0]  acc_o [NCH]
);

  localparam int ACC_W  = COEF_FRAC_BITS + INT_BITS;
  localparam int UW     = POS_FRAC_BITS + 1;
  localparam int PROD_W = ACC_W + UW + 1;

  logic signed [PROD_W-1:0] prod_d [NCH];
  logic signed [PROD_W-1:0] prod_q [NCH];
  logic signed [ACC_W-1:0]  acc_d  [NCH];
  logic signed [ACC_W-1:0]  acc_q  [NCH];
  logic signed [ACC_W-1:0]  coef   [NCH];
  logic [UW-1:0]            u_q1, u_q2;
  logic                     valid_q1, valid_q2;

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      coef[ch]   = ACC_W'(coef_fix(ch, POWER, COEF_FRAC_BITS));
      prod_d[ch] = PROD_W'(acc_i[ch]) * PROD_W'($signed({1'b0, u_i}));
      acc_d[ch]  = coef[ch] + ACC_W'(prod_q[ch] >>> POS_FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q1 <= 1'b0;
      valid_q2 <= 1'b0;
    end else begin
      valid_q1 <= valid_i;
      valid_q2 <= valid_q1;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q1   <= u_i;
    u_q2   <= u_q1;
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign valid_o = valid_q2;
  assign u_o     = u_q2;
  assign acc_o   = acc_q;

endmodule

// ===== rtl/mgc_clamp.sv =====
// output stage: scales each channel by 255, clamps and truncates to a byte
// depends on mgc_pkg
`timescale 1ns / 1ps

module mgc_clamp import mgc_pkg::*; #(
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       valid_i,
  input  logic signed [COEF_FRAC_BITS+INT_BITS-1:0]  acc_i [NCH],
  output logic                                       valid_o,
  output logic        [BYTE_W-1:0]                   byte_o [NCH]
);

  localparam int ACC_W = COEF_FRAC_BITS + INT_BITS;
  localparam int XW    = ACC_W + BYTE_W;

  logic signed [XW-1:0]     scaled [NCH];
  logic signed [XW-1:0]     quot   [NCH];
  logic        [BYTE_W-1:0] byte_d [NCH];
  logic        [BYTE_W-1:0] byte_q [NCH];
  logic                     valid_q;

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      scaled[ch] = (XW'(acc_i[ch]) <<< BYTE_W) - XW'(acc_i[ch]);
      quot[ch]   = scaled[ch] >>> COEF_FRAC_BITS;
      if (acc_i[ch] <= 0) begin
        byte_d[ch] = '0;
      end else if (quot[ch] > XW'(255)) begin
        byte_d[ch] = '1;
      end else begin
        byte_d[ch] = quot[ch][BYTE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

  a_neg_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (acc_i[CH_RED] <= 0) |=> (byte_o[CH_RED] == '0))
    else $error("non-positive red value did not give zero");

  a_valid_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |=> valid_o)
    else $error("clamp stage dropped a transaction");

endmodule

// ===== rtl/magma_polynomial_colormap.sv =====
// top level of the magma polynomial colormap pipeline
// depends on mgc_pkg, mgc_fold, mgc_horner_stage, mgc_clamp
`timescale 1ns / 1ps

// usage
//   a transaction is taken at each rising edge with start_i high and busy_o
//   low; busy_o is always low, so one position can enter every cycle.
//   position_i is t with POS_FRAC_BITS fraction bits, values above 1.0
//   saturate. each result appears on red_o, green_o and blue_o for one cycle
//   with valid_o high, in input order.
// pipeline and throughput
//   start_i to valid_o passes one fold stage, two stages per horner
//   step (multiply, then shift and add) over six steps, one clamp stage.
//   one transaction per cycle, set by the fully pipelined horner chain with
//   one multiplier per channel in each step.
// reset
//   rst_ni clears all valid bits at once; transactions in flight are lost.
// receiver
//   the receiver cannot stall; results are presented exactly once.

module magma_polynomial_colormap import mgc_pkg::*; #(
  parameter int POS_FRAC_BITS  = 16,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [POS_W-1:0]  position_i,
  output logic              valid_o,
  output logic [BYTE_W-1:0] red_o,
  output logic [BYTE_W-1:0] green_o,
  output logic [BYTE_W-1:0] blue_o
);

  localparam int ACC_W = COEF_FRAC_BITS + INT_BITS;
  localparam int UW    = POS_FRAC_BITS + 1;
  localparam int LAT   = 2 * DEG + 2;

  logic                    vld_s [DEG+1];
  logic [UW-1:0]           u_s   [DEG+1];
  logic signed [ACC_W-1:0] acc_s [DEG+1][NCH];
  logic [BYTE_W-1:0]       bytes [NCH];

  assign busy_o = 1'b0;

  mgc_fold #(
    .POS_FRAC_BITS(POS_FRAC_BITS)
  ) u_fold (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start_i),
    .position_i(position_i),
    .valid_o   (vld_s[0]),
    .u_o       (u_s[0])
  );

  for (genvar ch = 0; ch < NCH; ch++) begin : g_lead
    assign acc_s[0][ch] = ACC_W'(coef_fix(ch, DEG, COEF_FRAC_BITS));
  end

  for (genvar s = 0; s < DEG; s++) begin : g_step
    mgc_horner_stage #(
      .POS_FRAC_BITS (POS_FRAC_BITS),
      .COEF_FRAC_BITS(COEF_FRAC_BITS),
      .POWER         (DEG - 1 - s)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(vld_s[s]),
      .u_i    (u_s[s]),
      .acc_i  (acc_s[s]),
      .valid_o(vld_s[s+1]),
      .u_o    (u_s[s+1]),
      .acc_o  (acc_s[s+1])
    );
  end

  mgc_clamp #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_clamp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(vld_s[DEG]),
    .acc_i  (acc_s[DEG]),
    .valid_o(valid_o),
    .byte_o (bytes)
  );

  assign red_o   = bytes[CH_RED];
  assign green_o = bytes[CH_GREEN];
  assign blue_o  = bytes[CH_BLUE];

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, LAT))
    else $error("result without a matching transaction");

  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##LAT valid_o)
    else $error("transaction lost in the pipeline");

  a_dark_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (position_i == '0) |-> ##LAT
      (red_o == '0) && (green_o == '0) && (blue_o == '0))
    else $error("position zero did not map to black");

endmodule
